### hw/rtl/dtjd_pkg.sv
// ----------------------------------------------------------------------------
// dtjd_pkg
// Shared types, constants and lookup functions for the date to Julian day
// number converter.
// ----------------------------------------------------------------------------
`default_nettype none

package dtjd_pkg;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_DATE = 2'd1,
    STAT_BAD_TIME = 2'd2
  } status_t;

  localparam int YEAR_W   = 14;
  localparam int FIELD_W  = 7;
  localparam int JDN_W    = 23;
  localparam int WDAY_W   = 3;
  localparam int DCS_W    = 24;
  localparam int IN_W     = 56;
  localparam int OUT_W    = 56;

  localparam int YADJ_W   = 15;
  localparam int T2_W     = 9;
  localparam int HM_W     = 11;
  localparam int HMS_W    = 17;
  localparam int Q25_W    = 10;
  localparam int Q100_W   = 8;

  localparam logic [YADJ_W-1:0] YEAR_OFS_T1 = 15'd4800;
  localparam logic [YADJ_W-1:0] YEAR_OFS_T3 = 15'd4900;
  localparam logic [DCS_W-1:0]  JDN_BIAS    = 24'd32075;

  // floor(y/25) and floor(y/100) by reciprocal multiply, exact over the ranges used
  localparam int Y25_SHIFT  = 19;
  localparam logic [14:0] Y25_MUL  = 15'd20972;
  localparam int Y100_SHIFT = 22;
  localparam logic [15:0] Y100_MUL = 16'd41944;

  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // 367 * (shifted month) / 12, with January and February counted as months 11 and 12
  function automatic logic [T2_W-1:0] month_term(input logic [3:0] m);
    logic [T2_W-1:0] t;
    case (m)
      4'd1:    t = 9'd336;
      4'd2:    t = 9'd367;
      4'd3:    t = 9'd30;
      4'd4:    t = 9'd61;
      4'd5:    t = 9'd91;
      4'd6:    t = 9'd122;
      4'd7:    t = 9'd152;
      4'd8:    t = 9'd183;
      4'd9:    t = 9'd214;
      4'd10:   t = 9'd244;
      4'd11:   t = 9'd275;
      4'd12:   t = 9'd305;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // mod 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [WDAY_W-1:0] mod7(input logic [DCS_W-1:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
       + 6'(x[14:12]) + 6'(x[17:15]) + 6'(x[20:18]) + 6'(x[23:21]);
    s2 = 4'(s1[5:3]) + 4'(s1[2:0]);
    s3 = 3'(s2[3]) + s2[2:0];
    return (s3 == 3'd7) ? 3'd0 : s3;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/date_to_julian_day.sv
// ----------------------------------------------------------------------------
// date_to_julian_day
// Gregorian date and time of day to Julian day number, weekday and
// centiseconds since midnight, four register stages.
// ----------------------------------------------------------------------------
// Takes one beat per clock unless output back-pressure holds it, and returns one
// result beat per input beat, in order. The four pipeline stages each hold one
// item; a stage moves up whenever the stage ahead of it is empty or moving,
// so bubbles close up and a stalled output still lets earlier stages fill.
// Stage 1 checks the fields and looks up month constants, stage 2 applies
// the leap-year rule and the year multiplies, stage 3 sums the day number and
// scales the time of day, stage 4 forms the weekday and zeroes invalid items.
`default_nettype none

module date_to_julian_day
  import dtjd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  // year[13:0], month[20:14], day[27:21], hour[34:28], minute[41:35],
  // second[48:42], centisecond[55:49]
  input  wire logic [IN_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  // status[1:0], julian_day[24:2], weekday[27:25], day_centiseconds[51:28],
  // zero[55:52]
  output logic [OUT_W-1:0]      out_tdata
);

  logic [YEAR_W-1:0]  in_year;
  logic [FIELD_W-1:0] in_month, in_day, in_hour, in_minute, in_second, in_centisecond;

  assign in_year        = in_tdata[13:0];
  assign in_month       = in_tdata[20:14];
  assign in_day         = in_tdata[27:21];
  assign in_hour        = in_tdata[34:28];
  assign in_minute      = in_tdata[41:35];
  assign in_second      = in_tdata[48:42];
  assign in_centisecond = in_tdata[55:49];

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1
  logic                 early;
  logic [YEAR_W-1:0]    s1_year_r;
  logic [YADJ_W-1:0]    s1_ya_r, s1_ya_nxt, s1_yc_r, s1_yc_nxt;
  logic [T2_W-1:0]      s1_t2_r;
  logic [4:0]           s1_mlen_r;
  logic                 s1_month_ok_r, s1_feb_r, s1_time_ok_r, s1_y4z_r, s1_y16z_r;
  logic [FIELD_W-1:0]   s1_day_r, s1_second_r, s1_cs_r;
  logic [HM_W-1:0]      s1_hm_r, s1_hm_nxt;
  logic [Q25_W-1:0]     s1_q25_r, s1_q25_nxt;
  logic [28:0]          q25_prod;

  assign early     = (in_month <= 7'd2);
  assign s1_ya_nxt = YADJ_W'(in_year) + YEAR_OFS_T1 - YADJ_W'(early);
  assign s1_yc_nxt = YADJ_W'(in_year) + YEAR_OFS_T3 - YADJ_W'(early);
  assign s1_hm_nxt = HM_W'(13'(in_hour) * 13'd60 + 13'(in_minute));
  assign q25_prod  = 29'(in_year) * 29'(Y25_MUL);
  assign s1_q25_nxt = q25_prod[Y25_SHIFT +: Q25_W];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_year_r     <= in_year;
      s1_ya_r       <= s1_ya_nxt;
      s1_yc_r       <= s1_yc_nxt;
      s1_t2_r       <= month_term(in_month[3:0]);
      s1_mlen_r     <= month_len(in_month[3:0]);
      s1_month_ok_r <= (in_month >= 7'd1) && (in_month <= 7'd12);
      s1_feb_r      <= (in_month == 7'd2);
      s1_time_ok_r  <= (in_hour < 7'd24) && (in_minute < 7'd60) && (in_second < 7'd60);
      s1_y4z_r      <= (in_year[1:0] == 2'd0);
      s1_y16z_r     <= (in_year[3:0] == 4'd0);
      s1_day_r      <= in_day;
      s1_second_r   <= in_second;
      s1_cs_r       <= in_centisecond;
      s1_hm_r       <= s1_hm_nxt;
      s1_q25_r      <= s1_q25_nxt;
    end
  end

  // stage 2
  logic                 leap, y25z;
  logic [4:0]           len;
  status_t              s2_status_r, s2_status_nxt;
  logic [JDN_W-1:0]     s2_t1_r, s2_t1_nxt;
  logic [T2_W-1:0]      s2_t2_r;
  logic [FIELD_W-1:0]   s2_day_r, s2_cs_r;
  logic [Q100_W-1:0]    s2_q100_r, s2_q100_nxt;
  logic [HMS_W-1:0]     s2_hms_r, s2_hms_nxt;
  logic [24:0]          t1_prod;
  logic [30:0]          q100_prod;

  assign y25z = (s1_year_r == YEAR_W'(YEAR_W'(s1_q25_r) * YEAR_W'(25)));
  assign leap = s1_y4z_r && (!y25z || s1_y16z_r);
  assign len  = s1_mlen_r + 5'(s1_feb_r && leap);

  always_comb begin
    if (!s1_month_ok_r || (s1_day_r == 7'd0) || (s1_day_r > 7'(len))) begin
      s2_status_nxt = STAT_BAD_DATE;
    end else if (!s1_time_ok_r) begin
      s2_status_nxt = STAT_BAD_TIME;
    end else begin
      s2_status_nxt = STAT_OK;
    end
  end

  assign t1_prod     = 25'(s1_ya_r) * 25'd1461;
  assign s2_t1_nxt   = t1_prod[24:2];
  assign q100_prod   = 31'(s1_yc_r) * 31'(Y100_MUL);
  assign s2_q100_nxt = q100_prod[Y100_SHIFT +: Q100_W];
  assign s2_hms_nxt  = HMS_W'(s1_hm_r) * HMS_W'(60) + HMS_W'(s1_second_r);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_status_r <= s2_status_nxt;
      s2_t1_r     <= s2_t1_nxt;
      s2_t2_r     <= s1_t2_r;
      s2_day_r    <= s1_day_r;
      s2_cs_r     <= s1_cs_r;
      s2_q100_r   <= s2_q100_nxt;
      s2_hms_r    <= s2_hms_nxt;
    end
  end

  // stage 3
  logic [9:0]           t3_prod;
  logic [DCS_W-1:0]     s3_jdn_nxt;
  status_t              s3_status_r;
  logic [JDN_W-1:0]     s3_jdn_r;
  logic [DCS_W-1:0]     s3_dcs_r, s3_dcs_nxt;

  assign t3_prod    = 10'(s2_q100_r) * 10'd3;
  assign s3_jdn_nxt = DCS_W'(s2_t1_r) + DCS_W'(s2_t2_r) + DCS_W'(s2_day_r)
                    - DCS_W'(t3_prod[9:2]) - JDN_BIAS;
  assign s3_dcs_nxt = DCS_W'(s2_hms_r) * DCS_W'(100) + DCS_W'(s2_cs_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_status_r <= s2_status_r;
      s3_jdn_r    <= s3_jdn_nxt[JDN_W-1:0];
      s3_dcs_r    <= s3_dcs_nxt;
    end
  end

  // stage 4
  status_t              out_status_r;
  logic [JDN_W-1:0]     out_jdn_r;
  logic [WDAY_W-1:0]    out_wday_r, out_wday_nxt;
  logic [DCS_W-1:0]     out_dcs_r;
  logic                 ok3;

  assign ok3          = (s3_status_r == STAT_OK);
  assign out_wday_nxt = mod7(DCS_W'(s3_jdn_r) + DCS_W'(1));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_status_r <= s3_status_r;
      out_jdn_r    <= ok3 ? s3_jdn_r : '0;
      out_wday_r   <= ok3 ? out_wday_nxt : '0;
      out_dcs_r    <= ok3 ? s3_dcs_r : '0;
    end
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {4'd0, out_dcs_r, out_wday_r, out_jdn_r, out_status_r};

  a_stall_from_output : assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_status_r != STAT_OK)) |->
      ((out_jdn_r == '0) && (out_wday_r == '0) && (out_dcs_r == '0)))
    else $error("invalid item with nonzero result fields");

  a_wday_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_wday_r <= 3'd6))
    else $error("weekday out of range");

  a_s2_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !rdy3) |=> (v2_r && $stable(s2_t1_r) && $stable(s2_hms_r)))
    else $error("stage 2 lost its item while stalled");

endmodule

`default_nettype wire

### test/tb_date_to_julian_day.sv
// ----------------------------------------------------------------------------
// tb_date_to_julian_day
// Self-checking bench for the date to Julian day number converter. A short
// table of hand-picked dates runs first: calendar edges, leap years and each
// kind of invalid field. Random dates follow, most of them well-formed and
// the rest broken or plain noise. Each accepted input beat queues its
// predicted result. Each output beat is checked field by field against the
// oldest entry in that queue. Both sides insert random gaps, with one
// stretch that runs at full rate.
// ----------------------------------------------------------------------------

module tb_date_to_julian_day;
  timeunit 1ns;
  timeprecision 1ps;

  import dtjd_pkg::*;

  localparam int unsigned RANDOM_DATES   = 925;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct packed {
    logic [FIELD_W-1:0] centisecond;
    logic [FIELD_W-1:0] second;
    logic [FIELD_W-1:0] minute;
    logic [FIELD_W-1:0] hour;
    logic [FIELD_W-1:0] day;
    logic [FIELD_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_beat_t;

  typedef struct packed {
    logic [3:0]        pad;
    logic [DCS_W-1:0]  day_centiseconds;
    logic [WDAY_W-1:0] weekday;
    logic [JDN_W-1:0]  julian_day;
    logic [1:0]        status;
  } jd_result_t;

  typedef struct packed {
    date_beat_t date;
    bit         typed;
    jd_result_t want;
  } date_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [IN_W-1:0] in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [OUT_W-1:0] out_tdata;

  jd_result_t  jd_expect_q[$];
  date_row_t   date_table[$];
  jd_result_t  got_res;
  jd_result_t  want_res;
  int unsigned err_cnt;
  int unsigned idle_cycles;
  bit          moved;
  bit          steady;

  date_to_julian_day u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned days_in_month(input logic [YEAR_W-1:0] y,
                                                input logic [FIELD_W-1:0] m);
    int unsigned yy;
    yy = y;
    if (m < 1 || m > 12) return 0;
    if (m == 2) begin
      if ((yy % 4 == 0) && ((yy % 100 != 0) || (yy % 400 == 0))) return 29;
      return 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic jd_result_t predict_julian(input date_beat_t d);
    jd_result_t r;
    longint unsigned y;
    longint unsigned m;
    longint unsigned early;
    longint unsigned jdn;
    longint unsigned dcs;
    r = '0;
    y = d.year;
    m = d.month;
    if (d.day < 1 || d.day > days_in_month(d.year, d.month)) begin
      r.status = STAT_BAD_DATE;
    end else if (d.hour >= 24 || d.minute >= 60 || d.second >= 60) begin
      r.status = STAT_BAD_TIME;
    end else begin
      early = (m <= 2) ? 1 : 0;
      jdn = (1461 * (y + 4800 - early)) / 4
          + (367 * (m + 12 * early - 2)) / 12
          + d.day
          - (3 * ((y + 4900 - early) / 100)) / 4
          - 32075;
      dcs = ((longint'(d.hour) * 60 + d.minute) * 60 + d.second) * 100 + d.centisecond;
      r.status           = STAT_OK;
      r.julian_day       = JDN_W'(jdn);
      r.weekday          = WDAY_W'((jdn + 1) % 7);
      r.day_centiseconds = DCS_W'(dcs);
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic date_beat_t random_date();
    date_beat_t  d;
    int unsigned kind;
    int unsigned len;
    kind = $urandom_range(99, 0);
    d.year = ($urandom_range(9, 0) == 0) ? YEAR_W'($urandom) : YEAR_W'($urandom_range(9999, 0));
    d.month = FIELD_W'($urandom_range(12, 1));
    if (kind < 10) begin
      d.year  = ($urandom_range(1, 0) == 0) ? YEAR_W'(100 * $urandom_range(163, 0))
                                           : YEAR_W'(4 * $urandom_range(2499, 0));
      d.month = FIELD_W'(2);
    end
    len = days_in_month(d.year, d.month);
    d.day    = FIELD_W'((kind < 10) ? $urandom_range(29, 28) : $urandom_range(len, 1));
    d.hour   = FIELD_W'($urandom_range(23, 0));
    d.minute = FIELD_W'($urandom_range(59, 0));
    d.second = FIELD_W'($urandom_range(59, 0));
    d.centisecond = ($urandom_range(19, 0) == 0) ? FIELD_W'($urandom)
                                                : FIELD_W'($urandom_range(99, 0));
    if (kind >= 85) begin
      d = date_beat_t'(IN_W'({$urandom, $urandom}));
    end else if (kind >= 70) begin
      case ($urandom_range(5, 0))
        0: d.day    = FIELD_W'(len + 1);
        1: d.day    = '0;
        2: d.month  = ($urandom_range(1, 0) == 0) ? '0 : FIELD_W'($urandom_range(127, 13));
        3: d.hour   = FIELD_W'($urandom_range(127, 24));
        4: d.minute = FIELD_W'($urandom_range(127, 60));
        default: d.second = FIELD_W'($urandom_range(127, 60));
      endcase
    end
    return d;
  endfunction

  task automatic add_row(input int unsigned y, input int unsigned m, input int unsigned d,
                         input int unsigned h, input int unsigned mi, input int unsigned s,
                         input int unsigned cs, input bit typed, input status_t st,
                         input int unsigned jdn, input int unsigned wd,
                         input int unsigned dcs);
    date_row_t row;
    row.date.year        = YEAR_W'(y);
    row.date.month       = FIELD_W'(m);
    row.date.day         = FIELD_W'(d);
    row.date.hour        = FIELD_W'(h);
    row.date.minute      = FIELD_W'(mi);
    row.date.second      = FIELD_W'(s);
    row.date.centisecond = FIELD_W'(cs);
    row.typed                 = typed;
    row.want                  = '0;
    row.want.status           = st;
    row.want.julian_day       = JDN_W'(jdn);
    row.want.weekday          = WDAY_W'(wd);
    row.want.day_centiseconds = DCS_W'(dcs);
    date_table.push_back(row);
  endtask

  task automatic send_date(input date_beat_t item, input bit typed, input jd_result_t want);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = item;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    jd_expect_q.push_back(typed ? want : predict_julian(item));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid = 1'b0;
    while (jd_expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic note_error(input jd_result_t want, input jd_result_t got, input bit orphan);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) begin
      if (orphan) begin
        $display("%0t: result with no date pending: status %0d jdn %0d wday %0d dcs %0d",
                 $realtime, got.status, got.julian_day, got.weekday, got.day_centiseconds);
      end else begin
        $write("%0t: mismatch: exp status %0d jdn %0d wday %0d dcs %0d pad %0h,",
               $realtime, want.status, want.julian_day, want.weekday,
               want.day_centiseconds, want.pad);
        $display(" got status %0d jdn %0d wday %0d dcs %0d pad %0h",
                 got.status, got.julian_day, got.weekday, got.day_centiseconds, got.pad);
      end
    end
  endtask

  always @(posedge clk) begin
    moved = 1'b0;
    if (rst_n && in_tvalid && in_tready) moved = 1'b1;
    if (rst_n && out_tvalid && out_tready) begin
      moved   = 1'b1;
      got_res = jd_result_t'(out_tdata);
      if (jd_expect_q.size() == 0) begin
        note_error('0, got_res, 1'b1);
      end else begin
        want_res = jd_expect_q.pop_front();
        if (got_res.status !== want_res.status ||
            got_res.julian_day !== want_res.julian_day ||
            got_res.weekday !== want_res.weekday ||
            got_res.day_centiseconds !== want_res.day_centiseconds ||
            got_res.pad !== want_res.pad)
          note_error(want_res, got_res, 1'b0);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_date_to_julian_day: errors");
    $finish;
  end

  initial begin : result_side
    int unsigned hold;
    hold = 0;
    forever begin
      @(negedge clk);
      if (hold != 0) begin
        out_tready = 1'b0;
        hold--;
      end else begin
        out_tready = 1'b1;
        hold = steady ? 0 : pick_gap();
      end
    end
  end

  initial begin : date_side
    int unsigned n;
    date_row_t   row;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    err_cnt     = 0;
    idle_cycles = 0;
    steady      = 1'b0;

    add_row(2000,  1,  1,  0,  0,  0,   0, 1, STAT_OK, 2451545, 6, 0);
    add_row(2000,  1,  1, 23, 59, 59,  99, 1, STAT_OK, 2451545, 6, 8639999);
    add_row(   0,  1,  1,  0,  0,  0,   0, 0, STAT_OK, 0, 0, 0);
    add_row(9999, 12, 31, 23, 59, 59,  99, 0, STAT_OK, 0, 0, 0);
    add_row(16383, 12, 31, 12, 30, 30, 50, 0, STAT_OK, 0, 0, 0);
    add_row(16000, 2, 29,  1,  2,  3,   4, 0, STAT_OK, 0, 0, 0);
    add_row(2000,  2, 29,  6,  0,  0,   0, 0, STAT_OK, 0, 0, 0);
    add_row(2024,  2, 29, 18, 45, 10,  20, 0, STAT_OK, 0, 0, 0);
    add_row(1900,  2, 29,  0,  0,  0,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023,  2, 29,  0,  0,  0,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023,  0, 10,  0,  0,  0,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023, 13, 10,  0,  0,  0,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(16383, 127, 127, 127, 127, 127, 127, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023,  5,  0, 10,  0,  0,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023,  4, 31, 10,  0,  0,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023,  0,  5, 24, 60, 60,   0, 1, STAT_BAD_DATE, 0, 0, 0);
    add_row(2023,  6, 15, 24,  0,  0,   0, 1, STAT_BAD_TIME, 0, 0, 0);
    add_row(2023,  6, 15, 12, 60,  0,   0, 1, STAT_BAD_TIME, 0, 0, 0);
    add_row(2023,  6, 15, 12,  0, 60,   0, 1, STAT_BAD_TIME, 0, 0, 0);
    add_row(2023,  6, 15, 127, 127, 127, 127, 1, STAT_BAD_TIME, 0, 0, 0);
    add_row(2023,  1, 31, 23, 59, 59, 127, 0, STAT_OK, 0, 0, 0);
    add_row(2023,  3,  1,  0,  0,  0,   0, 0, STAT_OK, 0, 0, 0);
    add_row(2023, 12, 31,  0,  0,  0,   0, 0, STAT_OK, 0, 0, 0);
    add_row(1582, 10, 15,  0,  0,  0,   0, 0, STAT_OK, 0, 0, 0);
    add_row(2100,  2, 28,  9,  9,  9,   9, 0, STAT_OK, 0, 0, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (date_table[i]) begin
      row = date_table[i];
      send_date(row.date, row.typed, row.want);
    end
    drain_results();

    for (n = 0; n < RANDOM_DATES; n++) begin
      if (n == 300) drain_results();
      if (n == 400) steady = 1'b1;
      if (n == 550) steady = 1'b0;
      send_date(random_date(), 1'b0, '0);
    end
    drain_results();
    repeat (8) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_date_to_julian_day: clean");
    end else begin
      $display("tb_date_to_julian_day: errors");
    end
    $finish;
  end

endmodule
